### src/palette_color_merge_defines.svh
// ----------------------------------------------------------------------------
// palette_color_merge_defines.svh
// Assertion macros for the palette merge RTL.
// ----------------------------------------------------------------------------
`ifndef PALETTE_COLOR_MERGE_DEFINES_SVH
`define PALETTE_COLOR_MERGE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette merge assertion failed");

// Next-cycle implication, disabled while in reset
`define PCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette merge assertion failed");

`endif

### src/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// Types, constants and helpers for the palette color merge block.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int IDX_W               = 8;
    localparam int COLOR_W             = 24;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // match bits move LANE cells toward cell 0 per scan step
    localparam int LANE   = 8;
    localparam int LANE_W = 3;

    localparam logic [COLOR_W-1:0] BLACK        = 24'h000000;
    localparam logic [COLOR_W-1:0] LAST_DEFAULT = 24'h003f00;

    // input word
    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  src_index;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } pcm_in_t;

    // result word
    typedef struct packed {
        logic [IDX_W-1:0] remap_slot;
        logic [IDX_W-1:0] master_index;
        logic             skipped;
        logic             added;
    } pcm_out_t;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
        logic write;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic              found;
        logic [LANE_W-1:0] idx;
    } lane_pick_t;

    localparam logic CMD_CLEAR = 1'b1;

    // lowest set bit of one lane group
    function automatic lane_pick_t lane_first(input logic [LANE-1:0] bits);
        lane_pick_t pick;
        pick = '0;
        for (int j = LANE - 1; j >= 0; j--) begin
            if (bits[j]) begin
                pick.found = 1'b1;
                pick.idx   = LANE_W'(j);
            end
        end
        return pick;
    endfunction

endpackage

### src/palette_color_merge.sv
// ----------------------------------------------------------------------------
// palette_color_merge
// Merges source colors into a master palette with duplicate removal, using a
// chain of entry cells that compare in parallel and scan their match flags.
// ----------------------------------------------------------------------------
//  channel   handshake            payload     notes
//  input     start & !busy        item        cmd, src_index, red, green, blue
//  result    done (one cycle)     result      remap_slot, master_index, flags
//
//  Clear and black colors: busy for 1 cycle after accept.
//  Match in lane group k (entries 8k..8k+7): found once that group reaches the bottom lane.
//  New color: written at the fill position after the last scan step;
//  the match flags step 8 cells per cycle toward cell 0 during the scan.
//  done pulses in the first cycle with busy low; a new start may be taken then.
//  Reset loads the palette defaults directly; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "palette_color_merge_defines.svh"

module palette_color_merge
    import pcm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  pcm_in_t  item,
    output logic     busy,
    output logic     done,
    output pcm_out_t result
);

    localparam int POS_W  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int STEPS  = (PALETTE_ENTRIES + LANE - 1) / LANE;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(PALETTE_ENTRIES - 1);

    state_t             state_reg;
    state_t             state_next;
    logic               cmd_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [POS_W-1:0]   fill_reg;
    logic [POS_W-1:0]   fill_next;
    logic               done_reg;
    logic               done_next;
    pcm_out_t           result_reg;
    pcm_out_t           result_next;

    cell_ctrl_t                 ctrl;
    logic [PALETTE_ENTRIES-1:0] match_out;
    logic [LANE-1:0]            lane_bits;
    lane_pick_t                 pick;
    logic                       accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // chain of entry cells
    for (genvar i = 0; i < PALETTE_ENTRIES; i++)
    begin : g_cell
        logic match_in;
        if (i + LANE < PALETTE_ENTRIES)
        begin : g_link
            assign match_in = match_out[i + LANE];
        end
        else
        begin : g_end
            assign match_in = 1'b0;
        end

        pcm_cell #(
            .POS_W       (POS_W),
            .CELL_INDEX  (i),
            .RESET_COLOR ((i == PALETTE_ENTRIES - 1) ? LAST_DEFAULT : BLACK)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .key       (color_reg),
            .wr_pos    (fill_reg),
            .match_in  (match_in),
            .match_out (match_out[i])
        );
    end

    // bottom lane group as seen by the sequencer
    for (genvar j = 0; j < LANE; j++)
    begin : g_lane
        if (j < PALETTE_ENTRIES)
        begin : g_live
            assign lane_bits[j] = match_out[j];
        end
        else
        begin : g_none
            assign lane_bits[j] = 1'b0;
        end
    end

    assign pick = lane_first(lane_bits);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((cmd_reg == CMD_CLEAR) || (color_reg == BLACK))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pick.found || (step_reg == LAST_STEP))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs, cell controls and result word
    always_comb
    begin
        ctrl                     = '0;
        done_next                = 1'b0;
        step_next                = step_reg;
        fill_next                = fill_reg;
        result_next              = result_reg;
        result_next.remap_slot   = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_CLEAR)
                begin
                    ctrl.clear               = 1'b1;
                    fill_next                = '0;
                    done_next                = 1'b1;
                    result_next.master_index = '0;
                    result_next.skipped      = 1'b1;
                    result_next.added        = 1'b0;
                end
                else if (color_reg == BLACK)
                begin
                    done_next                = 1'b1;
                    result_next.master_index = '0;
                    result_next.skipped      = 1'b1;
                    result_next.added        = 1'b0;
                end
                else
                begin
                    ctrl.load = 1'b1;
                    step_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (pick.found)
                begin
                    done_next                = 1'b1;
                    result_next.master_index = IDX_W'({step_reg, pick.idx});
                    result_next.skipped      = 1'b0;
                    result_next.added        = 1'b0;
                end
                else if (step_reg == LAST_STEP)
                begin
                    // no match anywhere: store at the fill position
                    ctrl.write               = 1'b1;
                    done_next                = 1'b1;
                    result_next.master_index = IDX_W'(fill_reg);
                    result_next.skipped      = 1'b0;
                    result_next.added        = 1'b1;
                    fill_next = (fill_reg == LAST_POS) ? '0 : POS_W'(fill_reg + 1'b1);
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    step_next  = STEP_W'(step_reg + 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // captured input word and result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.cmd;
            slot_reg  <= item.src_index;
            color_reg <= {item.red, item.green, item.blue};
        end
        result_reg <= result_next;
    end

    // assertions
    `PCM_ASSERT_NOW(a_done_after_busy, clk, rst_n, done, $past(busy))
    `PCM_ASSERT_NOW(a_flags_exclusive, clk, rst_n, done, !(result.skipped && result.added))
    `PCM_ASSERT_NOW(a_skip_index_zero, clk, rst_n, done && result.skipped,
                    result.master_index == '0)
    `PCM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `PCM_ASSERT_NOW(a_step_bound, clk, rst_n, state_reg == ST_SCAN, step_reg <= LAST_STEP)

endmodule

### src/pcm_cell.sv
// ----------------------------------------------------------------------------
// pcm_cell
// One master palette entry: holds the color, compares it with the broadcast
// key and passes its match flag down the chain during the scan.
// ----------------------------------------------------------------------------
module pcm_cell
    import pcm_pkg::*;
#(
    parameter int                 POS_W       = 8,
    parameter int                 CELL_INDEX  = 0,
    parameter logic [COLOR_W-1:0] RESET_COLOR = '0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [COLOR_W-1:0] key,
    input  logic [POS_W-1:0]   wr_pos,
    input  logic               match_in,
    output logic               match_out
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_INDEX);

    logic [COLOR_W-1:0] entry_reg;
    logic [COLOR_W-1:0] entry_next;
    logic               match_reg;
    logic               match_next;

    // entry update: clear wins over write
    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.clear)
        begin
            entry_next = RESET_COLOR;
        end
        else if (ctrl.write && (wr_pos == MY_POS))
        begin
            entry_next = key;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // match flag: load from compare, then shift along the chain
    always_comb
    begin
        match_next = match_reg;
        priority if (ctrl.load)
        begin
            match_next = (entry_reg == key);
        end
        else if (ctrl.shift)
        begin
            match_next = match_in;
        end
        else
        begin
            match_next = match_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= RESET_COLOR;
            match_reg <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            match_reg <= match_next;
        end
    end

    assign match_out = match_reg;

endmodule
